// ----- sv/stereo_band_coherence_panning_analyzer_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stereo band analyzer
// Property forms used by sbcpa_back, the module that carries assertions.
// ----------------------------------------------------------------------------
`ifndef STEREO_BAND_COHERENCE_PANNING_ANALYZER_DEFINES_SVH
`define STEREO_BAND_COHERENCE_PANNING_ANALYZER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SBCPA_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbcpa: property failed");

// The consequent holds in the cycle after the antecedent.
`define SBCPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbcpa: property failed");

`endif

// ----- sv/sbcpa_pkg.sv -----
// ----------------------------------------------------------------------------
// sbcpa_pkg
// Types, constants and the arctangent table of the stereo band analyzer.
// ----------------------------------------------------------------------------
package sbcpa_pkg;

   localparam int ATAN_ITERATIONS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF     = 2;
   localparam int ATAN_MAX            = 24;
   localparam int ATAN_IDX_W          = 5;
   localparam int ONE_Q16             = 65536;
   localparam int AZ_LIMIT            = 25736;
   localparam int ICC_MAX             = 32768;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 31;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENERGY_ALPHA      = 3'd0,
      CSR_COHERENCE_ALPHA   = 3'd1,
      CSR_AZIMUTH_ALPHA     = 3'd2,
      CSR_CORRELATION_FLOOR = 3'd3,
      CSR_LEVEL_FLOOR       = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [16:0] energy_alpha;
      logic [16:0] coherence_alpha;
      logic [16:0] azimuth_alpha;
      logic [30:0] correlation_floor;
      logic [16:0] level_floor;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] mid;
      logic signed [15:0] side;
      logic        [30:0] ll;
      logic        [30:0] rr;
      logic signed [31:0] lr;
      logic        [31:0] lsum;
      logic               level_ok;
      logic        [16:0] mag_sum;
      logic signed [16:0] mag_diff;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_PROD,
      ST_SQRT,
      ST_CHECK,
      ST_DIV,
      ST_WAIT_AZ,
      ST_DONE
   } back_state_type;

   typedef enum logic [2:0] {
      SM_ENERGY,
      SM_LEFT,
      SM_RIGHT,
      SM_CROSS,
      SM_COHERENCE,
      SM_AZIMUTH
   } smooth_sel_type;

   function automatic logic [29:0] atan_angle(input logic [ATAN_IDX_W-1:0] idx);
      logic [29:0] v;
      unique case (idx)
         5'd0:    v = 30'd843314857;
         5'd1:    v = 30'd497837829;
         5'd2:    v = 30'd263043837;
         5'd3:    v = 30'd133525159;
         5'd4:    v = 30'd67021687;
         5'd5:    v = 30'd33543516;
         5'd6:    v = 30'd16775851;
         5'd7:    v = 30'd8388437;
         5'd8:    v = 30'd4194283;
         5'd9:    v = 30'd2097149;
         5'd10:   v = 30'd1048576;
         5'd11:   v = 30'd524288;
         5'd12:   v = 30'd262144;
         5'd13:   v = 30'd131072;
         5'd14:   v = 30'd65536;
         5'd15:   v = 30'd32768;
         5'd16:   v = 30'd16384;
         5'd17:   v = 30'd8192;
         5'd18:   v = 30'd4096;
         5'd19:   v = 30'd2048;
         5'd20:   v = 30'd1024;
         5'd21:   v = 30'd512;
         5'd22:   v = 30'd256;
         5'd23:   v = 30'd128;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- sv/sbcpa_front.sv -----
// ----------------------------------------------------------------------------
// sbcpa_front
// Accepts sample pairs and forms mid, side, products, magnitudes and the
// level decision for the back end.
// ----------------------------------------------------------------------------
module sbcpa_front (
   input  logic                      clock,
   input  logic                      reset,
   input  sbcpa_pkg::cfg_type        cfg,
   input  logic                      req_push,
   input  logic signed [15:0]        req_left_sample,
   input  logic signed [15:0]        req_right_sample,
   output logic                      req_full,
   input  logic                      q_full,
   output logic                      q_push,
   output sbcpa_pkg::item_type       q_item
);

   logic               valid_ff, valid_in;
   logic signed [15:0] left_ff, right_ff;
   logic               accept;
   logic signed [16:0] sum17, dif17, al, ar;
   logic signed [31:0] ll32, rr32, lr32;

   assign req_full = valid_ff & q_full;
   assign accept   = req_push & ~req_full;
   assign q_push   = valid_ff & ~q_full;
   assign valid_in = accept | (valid_ff & ~q_push);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         left_ff  <= req_left_sample;
         right_ff <= req_right_sample;
      end
   end

   always_comb begin
      sum17 = 17'(left_ff) + 17'(right_ff);
      dif17 = 17'(left_ff) - 17'(right_ff);
      ll32  = 32'(left_ff) * 32'(left_ff);
      rr32  = 32'(right_ff) * 32'(right_ff);
      lr32  = 32'(left_ff) * 32'(right_ff);
      al    = (left_ff < 0) ? -17'(left_ff) : 17'(left_ff);
      ar    = (right_ff < 0) ? -17'(right_ff) : 17'(right_ff);
      q_item.mid      = sum17[16:1];
      q_item.side     = dif17[16:1];
      q_item.ll       = ll32[30:0];
      q_item.rr       = rr32[30:0];
      q_item.lr       = lr32;
      q_item.lsum     = 32'(ll32[30:0]) + 32'(rr32[30:0]);
      q_item.mag_sum  = 17'($unsigned(al)) + 17'($unsigned(ar));
      q_item.mag_diff = ar - al;
      q_item.level_ok = (17'($unsigned(al)) + 17'($unsigned(ar))) > cfg.level_floor;
   end

endmodule

// ----- sv/sbcpa_queue.sv -----
// ----------------------------------------------------------------------------
// sbcpa_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module sbcpa_queue #(
   parameter int DEPTH = sbcpa_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sbcpa_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output sbcpa_pkg::item_type pop_item,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sbcpa_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- sv/sbcpa_cordic.sv -----
// ----------------------------------------------------------------------------
// sbcpa_cordic
// Iterative vectoring rotator giving twice the panning angle in Q2.14.
// ----------------------------------------------------------------------------
module sbcpa_cordic #(
   parameter int ITERATIONS = sbcpa_pkg::ATAN_ITERATIONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [16:0]        mag_sum,
   input  logic signed [16:0] mag_diff,
   output logic               done,
   output logic signed [15:0] angle
);

   localparam int STEPS = (ITERATIONS < sbcpa_pkg::ATAN_MAX) ? ITERATIONS
                                                             : sbcpa_pkg::ATAN_MAX;
   localparam int IW = sbcpa_pkg::ATAN_IDX_W;

   logic signed [43:0]  x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [33:0]  z_ff, z_in, ang;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                run_ff, run_in, done_ff, done_in;
   logic signed [34:0]  zr, zq;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      idx_in  = idx_ff;
      run_in  = run_ff;
      done_in = done_ff;
      xs      = x_ff >>> idx_ff;
      ys      = y_ff >>> idx_ff;
      ang     = 34'($signed({1'b0, sbcpa_pkg::atan_angle(idx_ff)}));
      if (start) begin
         x_in    = 44'($signed({1'b0, mag_sum})) <<< 24;
         y_in    = 44'(mag_diff) <<< 24;
         z_in    = '0;
         idx_in  = '0;
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == IW'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      idx_ff <= idx_in;
   end

   always_comb begin
      zr = 35'(z_ff) + 35'sd16384;
      zq = zr >>> 15;
      if (zq > 35'(sbcpa_pkg::AZ_LIMIT)) begin
         angle = 16'(sbcpa_pkg::AZ_LIMIT);
      end else if (zq < -35'(sbcpa_pkg::AZ_LIMIT)) begin
         angle = -16'(sbcpa_pkg::AZ_LIMIT);
      end else begin
         angle = zq[15:0];
      end
   end

   assign done = done_ff;

endmodule

// ----- sv/sbcpa_back.sv -----
// ----------------------------------------------------------------------------
// sbcpa_back
// Sequencer that updates the smoothed averages, finds the coherence with a
// bitwise square root and divider, and loads the result register.
// ----------------------------------------------------------------------------
`include "stereo_band_coherence_panning_analyzer_defines.svh"

module sbcpa_back (
   input  logic                      clock,
   input  logic                      reset,
   input  sbcpa_pkg::cfg_type        cfg,
   input  logic                      q_empty,
   output logic                      q_pop,
   input  sbcpa_pkg::item_type       q_item,
   output logic                      cordic_start,
   output logic [16:0]               cordic_mag_sum,
   output logic signed [16:0]        cordic_mag_diff,
   input  logic                      cordic_done,
   input  logic signed [15:0]        cordic_angle,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic signed [15:0]        rsp_mid_out,
   output logic signed [15:0]        rsp_side_out,
   output logic [15:0]               rsp_coherence_out,
   output logic signed [15:0]        rsp_azimuth_out,
   output logic [31:0]               rsp_energy_out
);

   sbcpa_pkg::back_state_type state_ff, state_in;
   sbcpa_pkg::smooth_sel_type sel_ff, sel_in;
   sbcpa_pkg::item_type       item_ff, item_in;

   logic [47:0]        energy_ff, energy_in, left_ff, left_in, right_ff, right_in;
   logic signed [47:0] cross_ff, cross_in;
   logic [31:0]        coh_ff, coh_in;
   logic signed [31:0] az_ff, az_in;
   logic signed [49:0] diff_ff, diff_in;
   logic [40:0]        plo_ff, plo_in;
   logic [63:0]        rem_ff, rem_in, root_ff, root_in;
   logic [4:0]         k_ff, k_in, dcnt_ff, dcnt_in;
   logic [32:0]        drem_ff, drem_in;
   logic [16:0]        dlow_ff, dlow_in, quot_ff, quot_in;
   logic [15:0]        icc_ff, icc_in;
   logic               start_ff, start_in;

   logic               out_valid_ff, out_valid_in, out_load;
   logic signed [15:0] mid_ff, side_ff, azo_ff, azo_in;
   logic [15:0]        coho_ff, coho_in;
   logic [31:0]        eno_ff, eno_in;

   logic signed [49:0] avg_cur, x_cur, upd;
   logic [16:0]        a_raw, a_clip;
   logic signed [43:0] phi;
   logic signed [67:0] total, step;
   logic [64:0]        bitv, trial;
   logic [32:0]        denom;
   logic [33:0]        dt;
   logic               ge;
   logic [16:0]        qfin;
   logic signed [15:0] az_val;
   logic [48:0]        e_r;
   logic [32:0]        c_r;
   logic signed [32:0] a_r;
   logic signed [16:0] a_s;

   always_comb begin
      az_val = item_ff.level_ok ? cordic_angle : 16'sd0;
      unique case (sel_ff)
         sbcpa_pkg::SM_ENERGY: begin
            avg_cur = $signed({2'b0, energy_ff});
            x_cur   = $signed(50'({item_ff.lsum, 16'b0}));
            a_raw   = cfg.energy_alpha;
         end
         sbcpa_pkg::SM_LEFT: begin
            avg_cur = $signed({2'b0, left_ff});
            x_cur   = $signed(50'({item_ff.ll, 16'b0}));
            a_raw   = cfg.coherence_alpha;
         end
         sbcpa_pkg::SM_RIGHT: begin
            avg_cur = $signed({2'b0, right_ff});
            x_cur   = $signed(50'({item_ff.rr, 16'b0}));
            a_raw   = cfg.coherence_alpha;
         end
         sbcpa_pkg::SM_CROSS: begin
            avg_cur = 50'(cross_ff);
            x_cur   = 50'(item_ff.lr) <<< 16;
            a_raw   = cfg.coherence_alpha;
         end
         sbcpa_pkg::SM_COHERENCE: begin
            avg_cur = $signed({18'b0, coh_ff});
            x_cur   = $signed(50'({icc_ff, 16'b0}));
            a_raw   = cfg.coherence_alpha;
         end
         sbcpa_pkg::SM_AZIMUTH: begin
            avg_cur = 50'(az_ff);
            x_cur   = 50'(az_val) <<< 16;
            a_raw   = cfg.azimuth_alpha;
         end
         default: begin
            avg_cur = '0;
            x_cur   = '0;
            a_raw   = '0;
         end
      endcase
      a_clip = (a_raw > 17'(sbcpa_pkg::ONE_Q16)) ? 17'(sbcpa_pkg::ONE_Q16) : a_raw;
      phi    = 44'($signed(diff_ff[49:24])) * 44'($signed({1'b0, a_clip}));
      total  = (68'(phi) <<< 24) + $signed({27'b0, plo_ff}) + 68'sd32768;
      step   = total >>> 16;
      upd    = avg_cur + step[49:0];
      bitv   = 65'(1) << {k_ff, 1'b0};
      trial  = 65'(root_ff) + bitv;
      denom  = root_ff[32:0];
      dt     = {drem_ff, dlow_ff[16]};
      ge     = (dt >= 34'(denom));
      qfin   = {quot_ff[15:0], ge};
      e_r    = 49'(energy_ff) + 49'd32768;
      c_r    = 33'(coh_ff) + 33'd32768;
      a_r    = 33'(az_ff) + 33'sd32768;
      a_s    = a_r[32:16];
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      item_in      = item_ff;
      energy_in    = energy_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      cross_in     = cross_ff;
      coh_in       = coh_ff;
      az_in        = az_ff;
      diff_in      = diff_ff;
      plo_in       = plo_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      k_in         = k_ff;
      dcnt_in      = dcnt_ff;
      drem_in      = drem_ff;
      dlow_in      = dlow_ff;
      quot_in      = quot_ff;
      icc_in       = icc_ff;
      start_in     = 1'b0;
      q_pop        = 1'b0;
      out_load     = 1'b0;
      coho_in      = c_r[31:16];
      eno_in       = e_r[47:16];
      if (a_s > 17'(sbcpa_pkg::AZ_LIMIT)) begin
         azo_in = 16'(sbcpa_pkg::AZ_LIMIT);
      end else if (a_s < -17'(sbcpa_pkg::AZ_LIMIT)) begin
         azo_in = -16'(sbcpa_pkg::AZ_LIMIT);
      end else begin
         azo_in = a_s[15:0];
      end
      unique case (state_ff)
         sbcpa_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               start_in = 1'b1;
               sel_in   = sbcpa_pkg::SM_ENERGY;
               state_in = sbcpa_pkg::ST_DIFF;
            end
         end
         sbcpa_pkg::ST_DIFF: begin
            diff_in  = x_cur - avg_cur;
            state_in = sbcpa_pkg::ST_MUL_LO;
         end
         sbcpa_pkg::ST_MUL_LO: begin
            plo_in   = 41'(diff_ff[23:0]) * 41'(a_clip);
            state_in = sbcpa_pkg::ST_MUL_HI;
         end
         sbcpa_pkg::ST_MUL_HI: begin
            state_in = sbcpa_pkg::ST_DIFF;
            unique case (sel_ff)
               sbcpa_pkg::SM_ENERGY: begin
                  energy_in = upd[47:0];
                  sel_in    = sbcpa_pkg::SM_LEFT;
               end
               sbcpa_pkg::SM_LEFT: begin
                  left_in = upd[47:0];
                  sel_in  = sbcpa_pkg::SM_RIGHT;
               end
               sbcpa_pkg::SM_RIGHT: begin
                  right_in = upd[47:0];
                  sel_in   = sbcpa_pkg::SM_CROSS;
               end
               sbcpa_pkg::SM_CROSS: begin
                  cross_in = $signed(upd[47:0]);
                  state_in = sbcpa_pkg::ST_PROD;
               end
               sbcpa_pkg::SM_COHERENCE: begin
                  coh_in   = upd[31:0];
                  state_in = sbcpa_pkg::ST_WAIT_AZ;
               end
               sbcpa_pkg::SM_AZIMUTH: begin
                  az_in    = $signed(upd[31:0]);
                  state_in = sbcpa_pkg::ST_DONE;
               end
               default: begin
                  state_in = sbcpa_pkg::ST_IDLE;
               end
            endcase
         end
         sbcpa_pkg::ST_PROD: begin
            rem_in   = 64'(left_ff[47:16]) * 64'(right_ff[47:16]);
            root_in  = '0;
            k_in     = 5'd31;
            state_in = sbcpa_pkg::ST_SQRT;
         end
         sbcpa_pkg::ST_SQRT: begin
            if (65'(rem_ff) >= trial) begin
               rem_in  = rem_ff - trial[63:0];
               root_in = (root_ff >> 1) + bitv[63:0];
            end else begin
               root_in = root_ff >> 1;
            end
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               state_in = sbcpa_pkg::ST_CHECK;
            end
         end
         sbcpa_pkg::ST_CHECK: begin
            sel_in   = sbcpa_pkg::SM_COHERENCE;
            state_in = sbcpa_pkg::ST_DIFF;
            if (root_ff <= 64'(cfg.correlation_floor) || cross_ff <= 48'sd0) begin
               icc_in = '0;
            end else if (33'(cross_ff[47:18]) >= denom) begin
               icc_in = 16'(sbcpa_pkg::ICC_MAX);
            end else begin
               drem_in  = 33'(cross_ff[47:18]);
               dlow_in  = {cross_ff[17:16], 15'b0};
               quot_in  = '0;
               dcnt_in  = 5'd16;
               state_in = sbcpa_pkg::ST_DIV;
            end
         end
         sbcpa_pkg::ST_DIV: begin
            drem_in = ge ? 33'(dt - 34'(denom)) : dt[32:0];
            quot_in = qfin;
            dlow_in = dlow_ff << 1;
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               icc_in   = (qfin > 17'(sbcpa_pkg::ICC_MAX)) ? 16'(sbcpa_pkg::ICC_MAX)
                                                           : qfin[15:0];
               state_in = sbcpa_pkg::ST_DIFF;
            end
         end
         sbcpa_pkg::ST_WAIT_AZ: begin
            if (cordic_done) begin
               sel_in   = sbcpa_pkg::SM_AZIMUTH;
               state_in = sbcpa_pkg::ST_DIFF;
            end
         end
         sbcpa_pkg::ST_DONE: begin
            if (!out_valid_ff) begin
               out_load = 1'b1;
               state_in = sbcpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbcpa_pkg::ST_IDLE;
         end
      endcase
      out_valid_in = out_load | (out_valid_ff & ~rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbcpa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_ff    <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         cross_ff     <= '0;
         coh_ff       <= '0;
         az_ff        <= '0;
         start_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         energy_ff    <= energy_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         cross_ff     <= cross_in;
         coh_ff       <= coh_in;
         az_ff        <= az_in;
         start_ff     <= start_in;
         out_valid_ff <= out_valid_in;
      end
      sel_ff  <= sel_in;
      item_ff <= item_in;
      diff_ff <= diff_in;
      plo_ff  <= plo_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      k_ff    <= k_in;
      dcnt_ff <= dcnt_in;
      drem_ff <= drem_in;
      dlow_ff <= dlow_in;
      quot_ff <= quot_in;
      icc_ff  <= icc_in;
      if (out_load) begin
         mid_ff  <= item_ff.mid;
         side_ff <= item_ff.side;
         coho_ff <= coho_in;
         azo_ff  <= azo_in;
         eno_ff  <= eno_in;
      end
   end

   assign cordic_start      = start_ff;
   assign cordic_mag_sum    = item_ff.mag_sum;
   assign cordic_mag_diff   = item_ff.mag_diff;
   assign rsp_empty         = ~out_valid_ff;
   assign rsp_mid_out       = mid_ff;
   assign rsp_side_out      = side_ff;
   assign rsp_coherence_out = coho_ff;
   assign rsp_azimuth_out   = azo_ff;
   assign rsp_energy_out    = eno_ff;

   `SBCPA_ASSERT_HOLDS(a_div_denom_nonzero, clock, reset, state_ff == sbcpa_pkg::ST_DIV, root_ff != '0)
   `SBCPA_ASSERT_HOLDS(a_icc_range, clock, reset, state_ff == sbcpa_pkg::ST_DIFF && sel_ff == sbcpa_pkg::SM_COHERENCE, icc_ff <= 16'(sbcpa_pkg::ICC_MAX))
   `SBCPA_ASSERT_NEXT(a_result_loaded, clock, reset, state_ff == sbcpa_pkg::ST_DONE && !out_valid_ff, out_valid_ff)
   `SBCPA_ASSERT_HOLDS(a_pop_needs_item, clock, reset, q_pop, !q_empty)

endmodule

// ----- sv/stereo_band_coherence_panning_analyzer.sv -----
// ----------------------------------------------------------------------------
// stereo_band_coherence_panning_analyzer
// Mid, side, smoothed energy, coherence and azimuth of a stereo sample pair.
// ----------------------------------------------------------------------------
// Each sample pair transfer yields one result, loaded into the result register
// once the previous result has been popped. A new pair can be taken while the
// previous one is processed. The back-end sequencer takes each pair through
// 32 steps of the bitwise square root, 17 steps of the coherence divider when
// it runs, six smoothing updates through the difference, low-multiply and
// high-multiply states, and five control steps; the panning rotator runs
// alongside. Configuration registers may be written whenever no pair is in
// flight.
module stereo_band_coherence_panning_analyzer #(
   parameter int ATAN_ITERATIONS = sbcpa_pkg::ATAN_ITERATIONS_DEF,
   parameter int QUEUE_DEPTH     = sbcpa_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [15:0]                   req_left_sample,
   input  logic signed [15:0]                   req_right_sample,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [15:0]                   rsp_mid_out,
   output logic signed [15:0]                   rsp_side_out,
   output logic [15:0]                          rsp_coherence_out,
   output logic signed [15:0]                   rsp_azimuth_out,
   output logic [31:0]                          rsp_energy_out,
   input  logic                                 csr_write_enable,
   input  logic [sbcpa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sbcpa_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   sbcpa_pkg::cfg_type  cfg_ff, cfg_in;
   sbcpa_pkg::item_type f_item, b_item;
   logic                f_push, q_full, q_empty, q_pop;
   logic                c_start, c_done;
   logic [16:0]         c_sum;
   logic signed [16:0]  c_diff;
   logic signed [15:0]  c_angle;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            sbcpa_pkg::CSR_ENERGY_ALPHA:      cfg_in.energy_alpha = csr_write_data[16:0];
            sbcpa_pkg::CSR_COHERENCE_ALPHA:   cfg_in.coherence_alpha = csr_write_data[16:0];
            sbcpa_pkg::CSR_AZIMUTH_ALPHA:     cfg_in.azimuth_alpha = csr_write_data[16:0];
            sbcpa_pkg::CSR_CORRELATION_FLOOR: cfg_in.correlation_floor = csr_write_data;
            sbcpa_pkg::CSR_LEVEL_FLOOR:       cfg_in.level_floor = csr_write_data[16:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.energy_alpha      <= 17'(sbcpa_pkg::ONE_Q16);
         cfg_ff.coherence_alpha   <= 17'(sbcpa_pkg::ONE_Q16);
         cfg_ff.azimuth_alpha     <= 17'(sbcpa_pkg::ONE_Q16);
         cfg_ff.correlation_floor <= 31'd1;
         cfg_ff.level_floor       <= 17'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbcpa_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_push         (req_push),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_full         (req_full),
      .q_full           (q_full),
      .q_push           (f_push),
      .q_item           (f_item)
   );

   sbcpa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_item (f_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (b_item),
      .empty     (q_empty)
   );

   sbcpa_cordic #(
      .ITERATIONS (ATAN_ITERATIONS)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .start    (c_start),
      .mag_sum  (c_sum),
      .mag_diff (c_diff),
      .done     (c_done),
      .angle    (c_angle)
   );

   sbcpa_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .q_item            (b_item),
      .cordic_start      (c_start),
      .cordic_mag_sum    (c_sum),
      .cordic_mag_diff   (c_diff),
      .cordic_done       (c_done),
      .cordic_angle      (c_angle),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_mid_out       (rsp_mid_out),
      .rsp_side_out      (rsp_side_out),
      .rsp_coherence_out (rsp_coherence_out),
      .rsp_azimuth_out   (rsp_azimuth_out),
      .rsp_energy_out    (rsp_energy_out)
   );

endmodule

// ----- dv/tb_stereo_band_coherence_panning_analyzer.sv -----
// ----------------------------------------------------------------------------
// Testbench for the stereo band coherence and panning analyzer
// Sends stereo sample pairs through the request queue and checks every
// response against an in-bench bit-accurate predictor of mid, side, energy,
// coherence and azimuth, over several register settings with random idling.
// ----------------------------------------------------------------------------
module tb_stereo_band_coherence_panning_analyzer;

   localparam int CLOCK_LIMIT  = 500000;
   localparam int HOLD_CYCLES  = 700;
   localparam int DRAIN_CYCLES = 120;
   localparam int CORDIC_STEPS = sbcpa_pkg::ATAN_ITERATIONS_DEF;
   localparam sbcpa_pkg::csr_index_type CSR_UNMAPPED =
      sbcpa_pkg::csr_index_type'(sbcpa_pkg::CSR_LEVEL_FLOOR + 1);

   typedef struct {
      logic signed [15:0] mid;
      logic signed [15:0] side;
      logic [15:0]        coherence;
      logic signed [15:0] azimuth;
      logic [31:0]        energy;
   } analysis_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [15:0] req_left_sample = '0;
   logic signed [15:0] req_right_sample = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [15:0] rsp_mid_out;
   logic signed [15:0] rsp_side_out;
   logic [15:0] rsp_coherence_out;
   logic signed [15:0] rsp_azimuth_out;
   logic [31:0] rsp_energy_out;
   logic csr_write_enable = 1'b0;
   sbcpa_pkg::csr_index_type csr_index = sbcpa_pkg::CSR_ENERGY_ALPHA;
   logic [sbcpa_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   // Predictor state and register copies.
   longint unsigned energy_acc, left_acc, right_acc, coherence_acc;
   longint cross_acc, azimuth_acc;
   longint unsigned energy_alpha, coherence_alpha, azimuth_alpha;
   longint unsigned correlation_floor, level_floor;
   longint atan_angles [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128};

   analysis_type pending_analyses[$];
   int mismatches = 0;
   int pairs_sent = 0;
   int responses_checked = 0;
   int config_writes = 0;
   int cycle_count = 0;
   bit push_on = 0;
   int burst_left = 0;
   bit hold_req = 0;
   int hold_left = 0;
   logic [15:0] stall_pat = '1;
   int pat_age = 0;

   stereo_band_coherence_panning_analyzer DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CLOCK_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic longint unsigned clip_alpha(longint unsigned a);
      return (a > sbcpa_pkg::ONE_Q16) ? longint'(sbcpa_pkg::ONE_Q16) : a;
   endfunction

   function automatic longint unsigned smooth_unsigned(longint unsigned avg,
         longint unsigned x, longint unsigned areg);
      longint unsigned a;
      a = clip_alpha(areg);
      return (avg * (sbcpa_pkg::ONE_Q16 - a) + x * a + 32768) >> 16;
   endfunction

   function automatic longint smooth_signed(longint avg, longint x,
         longint unsigned areg);
      longint a;
      a = longint'(clip_alpha(areg));
      return (avg * (sbcpa_pkg::ONE_Q16 - a) + x * a + 32768) >>> 16;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint pan_angle(longint s, longint d);
      longint x, y, z, xs, ys, r;
      x = s * 16777216;
      y = d * 16777216;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys; y = y - xs; z = z + atan_angles[i];
         end else begin
            x = x - ys; y = y + xs; z = z - atan_angles[i];
         end
      end
      r = (2 * z + 32768) >>> 16;
      if (r > sbcpa_pkg::AZ_LIMIT) r = sbcpa_pkg::AZ_LIMIT;
      if (r < -sbcpa_pkg::AZ_LIMIT) r = -sbcpa_pkg::AZ_LIMIT;
      return r;
   endfunction

   task automatic predict_analysis(input logic signed [15:0] ls,
         input logic signed [15:0] rs);
      longint l, r, ll, rr, lr, al, ar, az, azo;
      longint unsigned denom, icc;
      analysis_type a;
      l = ls;
      r = rs;
      ll = l * l;
      rr = r * r;
      lr = l * r;
      al = (l < 0) ? -l : l;
      ar = (r < 0) ? -r : r;
      az = 0;
      icc = 0;
      energy_acc = smooth_unsigned(energy_acc, longint'(ll + rr) << 16, energy_alpha);
      left_acc = smooth_unsigned(left_acc, longint'(ll) << 16, coherence_alpha);
      right_acc = smooth_unsigned(right_acc, longint'(rr) << 16, coherence_alpha);
      cross_acc = smooth_signed(cross_acc, lr * 65536, coherence_alpha);
      denom = int_sqrt((left_acc >> 16) * (right_acc >> 16));
      if (denom > correlation_floor && cross_acc > 0) begin
         icc = ((longint'(cross_acc) >> 16) << 15) / denom;
         if (icc > sbcpa_pkg::ICC_MAX) icc = sbcpa_pkg::ICC_MAX;
      end
      coherence_acc = smooth_unsigned(coherence_acc, icc << 16, coherence_alpha);
      if (al + ar > longint'(level_floor)) az = pan_angle(al + ar, ar - al);
      azimuth_acc = smooth_signed(azimuth_acc, az * 65536, azimuth_alpha);
      azo = (azimuth_acc + 32768) >>> 16;
      if (azo > sbcpa_pkg::AZ_LIMIT) azo = sbcpa_pkg::AZ_LIMIT;
      if (azo < -sbcpa_pkg::AZ_LIMIT) azo = -sbcpa_pkg::AZ_LIMIT;
      a.mid = 16'((l + r) >>> 1);
      a.side = 16'((l - r) >>> 1);
      a.coherence = 16'((coherence_acc + 32768) >> 16);
      a.azimuth = 16'(azo);
      a.energy = 32'((energy_acc + 32768) >> 16);
      pending_analyses.push_back(a);
   endtask

   task automatic report_mismatch(input string field, input longint got,
         input longint want);
      $display("Mismatch on response %0d: %s got %0d expected %0d",
               responses_checked, field, got, want);
      mismatches++;
   endtask

   // Response checker: outputs are stable at the falling edge, and a
   // transfer happens at the next rising edge when pop is high.
   initial begin
      analysis_type want;
      forever begin
         @(negedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (pending_analyses.size() == 0) begin
               $display("Response with no pair outstanding");
               mismatches++;
            end else begin
               want = pending_analyses.pop_front();
               if (rsp_mid_out !== want.mid)
                  report_mismatch("mid", rsp_mid_out, want.mid);
               if (rsp_side_out !== want.side)
                  report_mismatch("side", rsp_side_out, want.side);
               if (rsp_coherence_out !== want.coherence)
                  report_mismatch("coherence", rsp_coherence_out, want.coherence);
               if (rsp_azimuth_out !== want.azimuth)
                  report_mismatch("azimuth", rsp_azimuth_out, want.azimuth);
               if (rsp_energy_out !== want.energy)
                  report_mismatch("energy", rsp_energy_out, want.energy);
            end
            responses_checked++;
         end
      end
   end

   // Receiver stall pattern, with a long hold-off on request.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 0;
      end
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         if (pat_age == 0) begin
            stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            pat_age = 64;
         end
         pat_age--;
         rsp_pop <= stall_pat[pat_age % 16];
      end
   end

   task automatic send_pair(input logic signed [15:0] l, input logic signed [15:0] r);
      bit taken;
      if (burst_left == 0) burst_left = $urandom_range(1, 24);
      req_push <= 1'b1;
      push_on = 1;
      req_left_sample <= l;
      req_right_sample <= r;
      do begin
         @(negedge clock);
         taken = !req_full;
         @(posedge clock);
      end while (!taken);
      predict_analysis(l, r);
      pairs_sent++;
      burst_left--;
      if (burst_left == 0 && $urandom_range(0, 3) != 0) begin
         req_push <= 1'b0;
         push_on = 0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      if (push_on) begin
         req_push <= 1'b0;
         push_on = 0;
      end
      burst_left = 0;
      while (pending_analyses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input sbcpa_pkg::csr_index_type idx,
         input longint unsigned value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= sbcpa_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         sbcpa_pkg::CSR_ENERGY_ALPHA:      energy_alpha = value & 64'h1FFFF;
         sbcpa_pkg::CSR_COHERENCE_ALPHA:   coherence_alpha = value & 64'h1FFFF;
         sbcpa_pkg::CSR_AZIMUTH_ALPHA:     azimuth_alpha = value & 64'h1FFFF;
         sbcpa_pkg::CSR_CORRELATION_FLOOR: correlation_floor = value & 64'h7FFFFFFF;
         sbcpa_pkg::CSR_LEVEL_FLOOR:       level_floor = value & 64'h1FFFF;
         default: ;
      endcase
      config_writes++;
   endtask

   task automatic write_all(input longint unsigned ea, input longint unsigned ca,
         input longint unsigned aa, input longint unsigned cf, input longint unsigned lf);
      wait_idle();
      write_register(sbcpa_pkg::CSR_ENERGY_ALPHA, ea);
      write_register(sbcpa_pkg::CSR_COHERENCE_ALPHA, ca);
      write_register(sbcpa_pkg::CSR_AZIMUTH_ALPHA, aa);
      write_register(sbcpa_pkg::CSR_CORRELATION_FLOOR, cf);
      write_register(sbcpa_pkg::CSR_LEVEL_FLOOR, lf);
   endtask

   task automatic send_random_pairs(input int count);
      logic signed [15:0] l, r;
      for (int n = 0; n < count; n++) begin
         l = 16'($urandom);
         case ($urandom_range(0, 6))
            0: r = l;
            1: r = -l;
            2: r = l >>> $urandom_range(0, 6);
            3: begin
               l = 16'($signed($urandom_range(0, 8)) - 4);
               r = 16'($signed($urandom_range(0, 8)) - 4);
            end
            4: begin
               l = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               r = 16'($urandom);
            end
            default: r = 16'($urandom);
         endcase
         send_pair(l, r);
      end
   endtask

   task automatic test_directed_extremes();
      send_pair(16'sh0000, 16'sh0000);
      send_pair(16'sh7FFF, 16'sh7FFF);
      send_pair(16'sh8000, 16'sh8000);
      send_pair(16'sh7FFF, 16'sh8000);
      send_pair(16'sh8000, 16'sh7FFF);
      send_pair(16'sh0001, 16'sh0000);
      send_pair(16'sh0000, 16'sh0001);
      send_pair(-16'sd1, -16'sd1);
      send_pair(16'sh0000, 16'sh8000);
      send_pair(16'sh8000, 16'sh0000);
      send_pair(16'sh0000, 16'sh7FFF);
      send_pair(16'sh1234, -16'sh1234);
      send_pair(16'sh4000, 16'sh2000);
      send_pair(-16'sd3, 16'sd1);
      send_pair(16'sh0001, -16'sd1);
      send_pair(16'sh5555, -16'sh2AAA);
   endtask

   task automatic test_smoothing();
      write_all(4096, 2048, 8192, 1, 1);
      send_random_pairs(80);
   endtask

   task automatic test_frozen_averages();
      write_all(0, 0, 0, 0, 0);
      send_pair(16'sh7FFF, 16'sh8000);
      send_pair(16'sh0000, 16'sh0000);
      send_random_pairs(20);
   endtask

   task automatic test_alpha_above_one();
      write_all(131071, 70000, 65537, 1000, 3);
      wait_idle();
      write_register(CSR_UNMAPPED, 31'h7FFFFFFF);
      send_random_pairs(60);
   endtask

   task automatic test_floor_extremes();
      write_all(65536, 30000, 65536, 31'h7FFFFFFF, 65536);
      send_pair(16'sh7FFF, 16'sh7FFF);
      send_pair(16'sh8000, 16'sh8000);
      send_random_pairs(25);
      write_all(65536, 65536, 65536, 1073741824, 131071);
      send_random_pairs(25);
      write_all(1, 65535, 1, 12345678, 20);
      send_random_pairs(60);
   endtask

   task automatic test_full_queue();
      write_all(20000, 40000, 30000, 1, 1);
      hold_req = 1;
      burst_left = 40;
      send_random_pairs(40);
      send_random_pairs(60);
   endtask

   initial begin
      energy_acc = 0; left_acc = 0; right_acc = 0; coherence_acc = 0;
      cross_acc = 0; azimuth_acc = 0;
      energy_alpha = sbcpa_pkg::ONE_Q16;
      coherence_alpha = sbcpa_pkg::ONE_Q16;
      azimuth_alpha = sbcpa_pkg::ONE_Q16;
      correlation_floor = 1; level_floor = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      send_random_pairs(40);
      test_smoothing();
      test_frozen_averages();
      test_alpha_above_one();
      test_floor_extremes();
      test_full_queue();
      wait_idle();
      $display("Sent %0d sample pairs and checked %0d responses over %0d register writes.",
               pairs_sent, responses_checked, config_writes);
      $display("Settings ranged from no smoothing to frozen averages and saturated floors.");
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
